>>> sv/bis_pkg.sv
// Shared constants and types for the bitmap intersection scanner.
package bis_pkg;

    // Parameter defaults
    localparam int MAX_SETS_DEF   = 8;
    localparam int WORD_BITS_DEF  = 64;
    localparam int MAX_BLOCKS_DEF = 1024;

    // Fixed field widths
    localparam int NUM_SET_WORDS = 8;
    localparam int SET_WORD_W    = 64;
    localparam int BLOCK_W       = 10;
    localparam int LIMIT_W       = 11;
    localparam int SETS_W        = 4;
    localparam int ENTITY_W      = 16;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 11;

    // Width of one scan lane
    localparam int SEG_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT = CFG_IDX_W'(1);

    typedef logic [SET_WORD_W-1:0] set_word_t;

endpackage

>>> sv/bis_if.sv
// Channel interfaces: input blocks, result ids and configuration writes.
interface bis_item_if;
    logic                         valid;
    logic                         ready;
    logic [bis_pkg::BLOCK_W-1:0]  block_index;
    bis_pkg::set_word_t           set_word_0;
    bis_pkg::set_word_t           set_word_1;
    bis_pkg::set_word_t           set_word_2;
    bis_pkg::set_word_t           set_word_3;
    bis_pkg::set_word_t           set_word_4;
    bis_pkg::set_word_t           set_word_5;
    bis_pkg::set_word_t           set_word_6;
    bis_pkg::set_word_t           set_word_7;

    modport source (
        output valid, block_index, set_word_0, set_word_1, set_word_2, set_word_3,
               set_word_4, set_word_5, set_word_6, set_word_7,
        input  ready
    );
    modport sink (
        input  valid, block_index, set_word_0, set_word_1, set_word_2, set_word_3,
               set_word_4, set_word_5, set_word_6, set_word_7,
        output ready
    );
endinterface

interface bis_result_if;
    logic                         valid;
    logic                         ready;
    logic [bis_pkg::ENTITY_W-1:0] entity_id;
    logic                         last_in_block;

    modport source (output valid, entity_id, last_in_block, input ready);
    modport sink   (input  valid, entity_id, last_in_block, output ready);
endinterface

interface bis_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bis_pkg::CFG_IDX_W-1:0]  index;
    logic [bis_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

>>> sv/bis_seg_scan.sv
// One scan lane: lowest set bit within a narrow segment of the pending word.
module bis_seg_scan #(
    parameter int SEG_W = bis_pkg::SEG_W
) (
    input  logic [SEG_W-1:0]         seg,
    output logic                     hit,
    output logic [$clog2(SEG_W)-1:0] pos
);
    import bis_pkg::*;

    localparam int POS_W = $clog2(SEG_W);

    assign hit = |seg;

    // Walk down so the lowest set bit wins
    always_comb
    begin
        pos = '0;
        for (int i = SEG_W - 1; i >= 0; i--)
        begin
            if (seg[i])
            begin
                pos = POS_W'(i);
            end
        end
    end

endmodule

>>> sv/bis_scan_merge.sv
// Merging stage: picks the lowest lane with a hit and forms the bit index.
module bis_scan_merge #(
    parameter int NUM_SEG = 8,
    parameter int SEG_W   = bis_pkg::SEG_W
) (
    input  logic [NUM_SEG-1:0]                       seg_hit,
    input  logic [$clog2(SEG_W)-1:0]                 seg_pos [NUM_SEG],
    output logic                                     found,
    output logic [$clog2(NUM_SEG)+$clog2(SEG_W)-1:0] bit_idx
);
    import bis_pkg::*;

    localparam int SEL_W = $clog2(NUM_SEG);

    logic [SEL_W-1:0] sel;

    assign found = |seg_hit;

    // Lowest lane with a hit
    always_comb
    begin
        sel = '0;
        for (int g = NUM_SEG - 1; g >= 0; g--)
        begin
            if (seg_hit[g])
            begin
                sel = SEL_W'(g);
            end
        end
    end

    assign bit_idx = {sel, seg_pos[sel]};

endmodule

>>> sv/bitmap_intersection_scan.sv
// Top level: set-word AND, scan register, lane scanners and result register.
// A taken beat loads the pending-bits register; each id is then registered in the output register.
// Throughput: one id per cycle unless results stall; a block is held until its last matching
//   id is issued, and an empty or out-of-range block is not held; bits_reg sets this.
// Next block is taken once the pending-bits register has emptied.
// Reset: sets_in_use = 1, block_limit = 0, scanner and output register empty.
module bitmap_intersection_scan #(
    parameter int MAX_SETS   = bis_pkg::MAX_SETS_DEF,
    parameter int WORD_BITS  = bis_pkg::WORD_BITS_DEF,
    parameter int MAX_BLOCKS = bis_pkg::MAX_BLOCKS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bis_cfg_if.sink      cfg,
    bis_item_if.sink     items,
    bis_result_if.source results
);
    import bis_pkg::*;

    localparam int NUM_SEG = WORD_BITS / SEG_W;
    localparam int POS_W   = $clog2(SEG_W);
    localparam int BIT_W   = $clog2(WORD_BITS);

    // Registers
    logic [SETS_W-1:0]    sets_reg,      sets_next;
    logic [LIMIT_W-1:0]   limit_reg,     limit_next;
    logic [WORD_BITS-1:0] bits_reg,      bits_next;
    logic [BLOCK_W-1:0]   block_reg,     block_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ENTITY_W-1:0]  out_id_reg,    out_id_next;
    logic                 out_last_reg,  out_last_next;

    // Combinational
    set_word_t            words [NUM_SET_WORDS];
    set_word_t            and_word;
    logic [SETS_W-1:0]    nsets_eff;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 in_range;
    logic                 item_fire;
    logic                 busy;
    logic                 step;
    logic [WORD_BITS-1:0] bits_cleared;
    logic [NUM_SEG-1:0]   seg_hit;
    logic [POS_W-1:0]     seg_pos [NUM_SEG];
    logic                 scan_found;
    logic [BIT_W-1:0]     scan_idx;

    assign words[0] = items.set_word_0;
    assign words[1] = items.set_word_1;
    assign words[2] = items.set_word_2;
    assign words[3] = items.set_word_3;
    assign words[4] = items.set_word_4;
    assign words[5] = items.set_word_5;
    assign words[6] = items.set_word_6;
    assign words[7] = items.set_word_7;

    // Configuration: always ready; writes are expected only while idle
    assign cfg.ready = 1'b1;

    always_comb
    begin
        sets_next  = sets_reg;
        limit_next = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SETS_IN_USE: sets_next  = cfg.data[SETS_W-1:0];
                REG_BLOCK_LIMIT: limit_next = cfg.data;
                default:         ;
            endcase
        end
    end

    // Effective register values after saturation
    always_comb
    begin
        priority if (sets_reg == '0)
            nsets_eff = SETS_W'(1);
        else if (sets_reg > SETS_W'(MAX_SETS))
            nsets_eff = SETS_W'(MAX_SETS);
        else
            nsets_eff = sets_reg;
    end

    assign limit_eff = (limit_reg > LIMIT_W'(MAX_BLOCKS)) ? LIMIT_W'(MAX_BLOCKS) : limit_reg;
    assign in_range  = {1'b0, items.block_index} < limit_eff;

    // AND of the words in use; id zero is reserved
    always_comb
    begin
        and_word = '1;
        for (int i = 0; i < NUM_SET_WORDS; i++)
        begin
            if (i < MAX_SETS && SETS_W'(i) < nsets_eff)
            begin
                and_word = and_word & words[i];
            end
        end
        if (items.block_index == '0)
        begin
            and_word[0] = 1'b0;
        end
    end

    // Handshake
    assign busy        = |bits_reg;
    assign items.ready = ~busy;
    assign item_fire   = items.valid & items.ready;
    assign step        = busy & (~out_valid_reg | results.ready);

    // Scan lanes over the pending word
    for (genvar g = 0; g < NUM_SEG; g++)
    begin : g_lane
        bis_seg_scan #(
            .SEG_W (SEG_W)
        ) u_seg (
            .seg (bits_reg[g*SEG_W +: SEG_W]),
            .hit (seg_hit[g]),
            .pos (seg_pos[g])
        );
    end

    bis_scan_merge #(
        .NUM_SEG (NUM_SEG),
        .SEG_W   (SEG_W)
    ) u_merge (
        .seg_hit (seg_hit),
        .seg_pos (seg_pos),
        .found   (scan_found),
        .bit_idx (scan_idx)
    );

    // Drop the lowest set bit
    assign bits_cleared = bits_reg & (bits_reg - WORD_BITS'(1));

    // Scan and output register
    always_comb
    begin
        bits_next      = bits_reg;
        block_next     = block_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (item_fire && in_range)
        begin
            bits_next  = WORD_BITS'(and_word);
            block_next = items.block_index;
        end
        else if (step)
        begin
            bits_next      = bits_cleared;
            out_valid_next = 1'b1;
            out_id_next    = ENTITY_W'({block_reg, scan_idx});
            out_last_next  = (bits_cleared == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_reg      <= SETS_W'(1);
            limit_reg     <= '0;
            bits_reg      <= '0;
            block_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            sets_reg      <= sets_next;
            limit_reg     <= limit_next;
            bits_reg      <= bits_next;
            block_reg     <= block_next;
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.entity_id     = out_id_reg;
    assign results.last_in_block = out_last_reg;

    // Assertions
    a_no_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.entity_id != '0)
        else $error("reserved id zero emitted");

    a_lane_hit: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> scan_found)
        else $error("pending bits but no lane found a hit");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (step && bits_cleared == '0) |=> (results.last_in_block && !busy))
        else $error("last id issued but scanner not empty");

    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.last_in_block) |-> busy)
        else $error("non-final id held with nothing left to scan");

endmodule
